// ===== rtl/sel_pkg.sv =====
// ----------------------------------------------------------------------------
// sel_pkg
// Shared types and constants of the s-expression lexer: token kinds,
// character codes, the token record and the queue entry.
// ----------------------------------------------------------------------------
package sel_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int FIELD_BITS            = 16;
    localparam int KIND_BITS             = 3;
    localparam int CFG_INDEX_BITS        = 8;
    localparam int QUEUE_DEPTH           = 2;
    localparam int QUEUE_PTR_BITS        = $clog2(QUEUE_DEPTH);
    localparam int TDATA_OUT_BITS        = 64;
    localparam int TDATA_IN_BITS         = 8;

    localparam logic [KIND_BITS-1:0] KIND_SYMBOL  = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_NUMBER  = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_INVALID = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_STRING  = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_END     = 3'd6;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_LINE   = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_COLUMN = 8'd1;

    localparam logic [7:0] CHAR_PLUS    = "+";
    localparam logic [7:0] CHAR_MINUS   = "-";
    localparam logic [7:0] CHAR_STAR    = "*";
    localparam logic [7:0] CHAR_SLASH   = "/";
    localparam logic [7:0] CHAR_EQUAL   = "=";
    localparam logic [7:0] CHAR_GREATER = ">";
    localparam logic [7:0] CHAR_LESS    = "<";
    localparam logic [7:0] CHAR_DOT     = ".";
    localparam logic [7:0] CHAR_LPAREN  = "(";
    localparam logic [7:0] CHAR_RPAREN  = ")";
    localparam logic [7:0] CHAR_NEWLINE = "\n";
    localparam logic [7:0] CHAR_TAB     = "\t";
    localparam logic [7:0] CHAR_SPACE   = " ";
    localparam logic [7:0] CHAR_QUOTE   = "\"";
    localparam logic [7:0] CHAR_0       = "0";
    localparam logic [7:0] CHAR_9       = "9";
    localparam logic [7:0] CHAR_LOWER_A = "a";
    localparam logic [7:0] CHAR_LOWER_Z = "z";
    localparam logic [7:0] CHAR_UPPER_A = "A";
    localparam logic [7:0] CHAR_UPPER_Z = "Z";

    // The kind travels on tuser; the four position fields fill tdata.
    typedef struct packed {
        logic [FIELD_BITS-1:0] column;
        logic [FIELD_BITS-1:0] line;
        logic [FIELD_BITS-1:0] end_offset;
        logic [FIELD_BITS-1:0] start_offset;
        logic [KIND_BITS-1:0]  token_kind;
    } t_token;

    typedef struct packed {
        t_token first;
        t_token second;
        logic   two;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ===== rtl/s_expression_lexer_unit.sv =====
// ----------------------------------------------------------------------------
// s_expression_lexer_unit
// Lexer for s-expression source text, one byte per beat.
//
// Bytes enter on the s_axis group: tdata holds the byte and tlast marks the end
// of a source, which flushes any pending token, emits an end token and restarts
// the counters. Tokens leave on m_axis, one per beat: tuser is the token kind,
// tdata the offsets and start position, tlast the final token of a byte. The cfg
// channel writes first_line (index 0) and first_column (index 1), always ready.
//
// A byte is accepted every cycle while the two-entry token queue has room. Its
// first token goes through the queue and the output register to m_axis, and a
// byte that gives two tokens holds the output for both beats. Bytes giving at
// most one token each sustain one byte per cycle while the receiver is ready;
// the single output sets the pace otherwise. On a receiver stall the output
// register holds its beat and the queue fills; s_axis tready then falls. Reset
// empties the queue and output, sets both registers to 1 and clears the lexer
// state, including the halt that follows an invalid byte or a double quote.
// ----------------------------------------------------------------------------
module s_expression_lexer_unit #(
    parameter int POSITION_BITS = sel_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [sel_pkg::TDATA_IN_BITS-1:0]     i_s_tdata,   // byte_value
    input  logic                                  i_s_tlast,   // end_of_source
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // start_offset, end_offset, line, column
    output logic [sel_pkg::TDATA_OUT_BITS-1:0]    o_m_tdata,
    output logic [sel_pkg::KIND_BITS-1:0]         o_m_tuser,   // token_kind
    output logic                                  o_m_tlast,   // last
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sel_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [sel_pkg::FIELD_BITS-1:0]        i_cfg_data
);

    sel_pkg::t_entry        front_entry;
    sel_pkg::t_entry        head;
    sel_pkg::t_queue_status q_status;
    sel_pkg::t_token        out_token;
    logic                   push;
    logic                   pop;
    logic                   in_accept;

    assign o_s_tready  = !q_status.full;
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_s_tvalid && o_s_tready;

    sel_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_byte_value    (i_s_tdata),
        .i_end_of_source (i_s_tlast),
        .i_cfg_write     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_push          (push),
        .o_entry         (front_entry)
    );

    sel_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (front_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    sel_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_status (q_status),
        .o_pop    (pop),
        .i_ready  (i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_token  (out_token),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = {out_token.column, out_token.line, out_token.end_offset,
                        out_token.start_offset};
    assign o_m_tuser = out_token.token_kind;

`ifndef NO_ASSERTIONS
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == sel_pkg::KIND_END)) |-> o_m_tlast)
        else $error("end token not marked last");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && ((o_m_tuser == sel_pkg::KIND_INVALID) ||
                        (o_m_tuser == sel_pkg::KIND_STRING))) |-> o_m_tlast)
        else $error("error token not marked last");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
`endif

endmodule

// ===== rtl/sel_front.sv =====
// ----------------------------------------------------------------------------
// sel_front
// Accepts source bytes, keeps the lexer mode and position counters, and
// pushes the one or two tokens that a byte gives into the queue.
// ----------------------------------------------------------------------------
module sel_front #(
    parameter int POSITION_BITS = sel_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [7:0]                          i_byte_value,
    input  logic                                i_end_of_source,
    input  logic                                i_cfg_write,
    input  logic [sel_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [sel_pkg::FIELD_BITS-1:0]      i_cfg_data,
    output logic                                o_push,
    output sel_pkg::t_entry                     o_entry
);

    localparam int P = POSITION_BITS;
    localparam logic [P-1:0] POS_MAX = '1;
    localparam logic [sel_pkg::FIELD_BITS-1:0] RESET_FIRST = 16'd1;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_INT  = 2'd1;
    localparam logic [1:0] MODE_FRAC = 2'd2;
    localparam logic [1:0] MODE_SYM  = 2'd3;

    function automatic logic [P-1:0] sat_inc(input logic [P-1:0] x);
        sat_inc = (x == POS_MAX) ? x : x + 1'b1;
    endfunction

    function automatic logic [P-1:0] clamp_pos(input logic [sel_pkg::FIELD_BITS-1:0] v);
        logic [32:0] wide;
        logic [32:0] lim;
        wide = 33'(v);
        lim  = 33'(POS_MAX);
        clamp_pos = (wide > lim) ? POS_MAX : wide[P-1:0];
    endfunction

    function automatic logic [sel_pkg::FIELD_BITS-1:0] to_field(input logic [P-1:0] x);
        logic [31:0] wide;
        wide = 32'(x);
        to_field = wide[sel_pkg::FIELD_BITS-1:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= sel_pkg::CHAR_0) && (c <= sel_pkg::CHAR_9);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = ((c >= sel_pkg::CHAR_LOWER_A) && (c <= sel_pkg::CHAR_LOWER_Z)) ||
                    ((c >= sel_pkg::CHAR_UPPER_A) && (c <= sel_pkg::CHAR_UPPER_Z));
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        is_op = (c == sel_pkg::CHAR_PLUS) || (c == sel_pkg::CHAR_MINUS) ||
                (c == sel_pkg::CHAR_STAR) || (c == sel_pkg::CHAR_SLASH) ||
                (c == sel_pkg::CHAR_EQUAL) || (c == sel_pkg::CHAR_GREATER) ||
                (c == sel_pkg::CHAR_LESS);
    endfunction

    logic [1:0]                     r_mode, n_mode;
    logic [P-1:0]                   r_off, n_off;
    logic [P-1:0]                   r_line, n_line;
    logic [P-1:0]                   r_col, n_col;
    logic [P-1:0]                   r_tso, n_tso;
    logic [P-1:0]                   r_tsl, n_tsl;
    logic [P-1:0]                   r_tsc, n_tsc;
    logic                           r_halted, n_halted;
    logic [sel_pkg::FIELD_BITS-1:0] r_first_line, n_first_line;
    logic [sel_pkg::FIELD_BITS-1:0] r_first_col, n_first_col;

    logic            cont;
    logic            flush_v;
    logic            sec_v;
    logic            fresh;
    sel_pkg::t_token flush_tok;
    sel_pkg::t_token sec_tok;

    always_comb begin
        n_mode       = r_mode;
        n_off        = r_off;
        n_line       = r_line;
        n_col        = r_col;
        n_tso        = r_tso;
        n_tsl        = r_tsl;
        n_tsc        = r_tsc;
        n_halted     = r_halted;
        n_first_line = r_first_line;
        n_first_col  = r_first_col;
        cont         = 1'b0;
        flush_v      = 1'b0;
        sec_v        = 1'b0;
        fresh        = (r_off == '0) && (r_mode == MODE_IDLE);

        flush_tok.token_kind   = (r_mode == MODE_SYM) ? sel_pkg::KIND_SYMBOL
                                                      : sel_pkg::KIND_NUMBER;
        flush_tok.start_offset = to_field(r_tso);
        flush_tok.end_offset   = to_field(r_off);
        flush_tok.line         = to_field(r_tsl);
        flush_tok.column       = to_field(r_tsc);

        sec_tok.token_kind   = sel_pkg::KIND_END;
        sec_tok.start_offset = to_field(r_off);
        sec_tok.end_offset   = to_field(sat_inc(r_off));
        sec_tok.line         = to_field(r_line);
        sec_tok.column       = to_field(r_col);

        if (i_accept && !r_halted) begin
            if (i_end_of_source) begin
                flush_v            = (r_mode != MODE_IDLE);
                sec_v              = 1'b1;
                sec_tok.end_offset = to_field(r_off);
                n_mode             = MODE_IDLE;
                n_off              = '0;
                n_line             = clamp_pos(r_first_line);
                n_col              = clamp_pos(r_first_col);
            end else begin
                case (r_mode)
                    MODE_INT: begin
                        cont = is_digit(i_byte_value) || (i_byte_value == sel_pkg::CHAR_DOT);
                    end
                    MODE_FRAC: begin
                        cont = is_digit(i_byte_value);
                    end
                    MODE_SYM: begin
                        cont = is_letter(i_byte_value) || is_digit(i_byte_value) ||
                               is_op(i_byte_value);
                    end
                    default: begin
                        cont = 1'b0;
                    end
                endcase

                if (cont) begin
                    if ((r_mode == MODE_INT) && (i_byte_value == sel_pkg::CHAR_DOT)) begin
                        n_mode = MODE_FRAC;
                    end
                    n_off = sat_inc(r_off);
                    n_col = sat_inc(r_col);
                end else begin
                    flush_v = (r_mode != MODE_IDLE);
                    n_mode  = MODE_IDLE;
                    if ((i_byte_value == sel_pkg::CHAR_LPAREN) ||
                        (i_byte_value == sel_pkg::CHAR_RPAREN)) begin
                        sec_v              = 1'b1;
                        sec_tok.token_kind = (i_byte_value == sel_pkg::CHAR_LPAREN)
                                             ? sel_pkg::KIND_LPAREN : sel_pkg::KIND_RPAREN;
                        n_off              = sat_inc(r_off);
                        n_col              = sat_inc(r_col);
                    end else if (i_byte_value == sel_pkg::CHAR_NEWLINE) begin
                        n_off  = sat_inc(r_off);
                        n_line = sat_inc(r_line);
                        n_col  = clamp_pos(r_first_col);
                    end else if ((i_byte_value == sel_pkg::CHAR_SPACE) ||
                                 (i_byte_value == sel_pkg::CHAR_TAB)) begin
                        n_off = sat_inc(r_off);
                        n_col = sat_inc(r_col);
                    end else if (is_digit(i_byte_value) || is_letter(i_byte_value) ||
                                 is_op(i_byte_value)) begin
                        n_mode = is_digit(i_byte_value) ? MODE_INT : MODE_SYM;
                        n_tso  = r_off;
                        n_tsl  = r_line;
                        n_tsc  = r_col;
                        n_off  = sat_inc(r_off);
                        n_col  = sat_inc(r_col);
                    end else begin
                        sec_v              = 1'b1;
                        sec_tok.token_kind = (i_byte_value == sel_pkg::CHAR_QUOTE)
                                             ? sel_pkg::KIND_STRING : sel_pkg::KIND_INVALID;
                        n_halted           = 1'b1;
                    end
                end
            end
        end

        if (i_cfg_write) begin
            if (i_cfg_index == sel_pkg::REG_FIRST_LINE) begin
                n_first_line = i_cfg_data;
                if (fresh) begin
                    n_line = clamp_pos(i_cfg_data);
                end
            end else if (i_cfg_index == sel_pkg::REG_FIRST_COLUMN) begin
                n_first_col = i_cfg_data;
                if (fresh) begin
                    n_col = clamp_pos(i_cfg_data);
                end
            end
        end
    end

    always_comb begin
        o_push = flush_v || sec_v;
        if (flush_v) begin
            o_entry.first  = flush_tok;
            o_entry.second = sec_tok;
            o_entry.two    = sec_v;
        end else begin
            o_entry.first  = sec_tok;
            o_entry.second = sec_tok;
            o_entry.two    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_off        <= '0;
            r_line       <= clamp_pos(RESET_FIRST);
            r_col        <= clamp_pos(RESET_FIRST);
            r_tso        <= '0;
            r_tsl        <= '0;
            r_tsc        <= '0;
            r_halted     <= 1'b0;
            r_first_line <= RESET_FIRST;
            r_first_col  <= RESET_FIRST;
        end else begin
            r_mode       <= n_mode;
            r_off        <= n_off;
            r_line       <= n_line;
            r_col        <= n_col;
            r_tso        <= n_tso;
            r_tsl        <= n_tsl;
            r_tsc        <= n_tsc;
            r_halted     <= n_halted;
            r_first_line <= n_first_line;
            r_first_col  <= n_first_col;
        end
    end

endmodule

// ===== rtl/sel_queue.sv =====
// ----------------------------------------------------------------------------
// sel_queue
// Short register queue of token entries between the front and back parts.
// ----------------------------------------------------------------------------
module sel_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  sel_pkg::t_entry        i_entry,
    input  logic                   i_pop,
    output sel_pkg::t_entry        o_head,
    output sel_pkg::t_queue_status o_status
);

    localparam int D  = sel_pkg::QUEUE_DEPTH;
    localparam int PW = sel_pkg::QUEUE_PTR_BITS;
    localparam int CW = $clog2(D + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(D - 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(D);

    sel_pkg::t_entry r_mem [D];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push;
    logic            do_pop;

    always_comb begin
        do_push = i_push && (r_count != COUNT_FULL);
        do_pop  = i_pop && (r_count != '0);
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    assign o_head         = r_mem[r_rptr];
    assign o_status.full  = (r_count == COUNT_FULL);
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/sel_back.sv =====
// ----------------------------------------------------------------------------
// sel_back
// Takes queue entries apart into single token beats and holds each one in
// the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module sel_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sel_pkg::t_entry        i_head,
    input  sel_pkg::t_queue_status i_status,
    output logic                   o_pop,
    input  logic                   i_ready,
    output logic                   o_valid,
    output sel_pkg::t_token        o_token,
    output logic                   o_last
);

    logic            r_valid, n_valid;
    logic            r_phase, n_phase;
    logic            r_last, n_last;
    sel_pkg::t_token r_token, n_token;
    logic            load;

    always_comb begin
        load    = (!r_valid || i_ready) && !i_status.empty;
        n_valid = r_valid;
        n_phase = r_phase;
        n_last  = r_last;
        n_token = r_token;
        o_pop   = 1'b0;
        if (!r_valid || i_ready) begin
            n_valid = !i_status.empty;
        end
        if (load) begin
            n_token = r_phase ? i_head.second : i_head.first;
            n_last  = r_phase || !i_head.two;
            if (r_phase || !i_head.two) begin
                o_pop   = 1'b1;
                n_phase = 1'b0;
            end else begin
                n_phase = 1'b1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_token = r_token;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_token <= n_token;
        r_last  <= n_last;
    end

endmodule
